/* src/elca_pkg.sv */
// Package: shared types and constants for the edge LED colour averager.
package elca_pkg;

  localparam int CH_BITS = 20;
  localparam int SUM_BITS = 3 * CH_BITS;

  // configuration register indexes
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_LEFT     = 3'd2;
  localparam logic [2:0] REG_RIGHT    = 3'd3;
  localparam logic [2:0] REG_TOP      = 3'd4;
  localparam logic [2:0] REG_BOTTOM   = 3'd5;
  localparam logic [2:0] REG_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_CLOCKWISE = 3'd7;

  // edge codes
  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_code_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_LMUL,
    ST_LCHK,
    ST_EDGE,
    ST_RMW,
    ST_SORT,
    ST_DIV,
    ST_OUT
  } state_t;

  // result handed from the divider to the output stage
  typedef struct packed {
    logic [9:0] led_index;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       last_of_run;
  } result_t;

  // adds a pixel into a packed three-channel sum
  function automatic logic [SUM_BITS-1:0] add_pixel(
    input logic [SUM_BITS-1:0] acc, input logic fresh,
    input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    logic [CH_BITS-1:0] ar, ag, ab;
    begin
      ar = fresh ? '0 : acc[CH_BITS-1:0];
      ag = fresh ? '0 : acc[2*CH_BITS-1:CH_BITS];
      ab = fresh ? '0 : acc[3*CH_BITS-1:2*CH_BITS];
      ar = ar + CH_BITS'(r);
      ag = ag + CH_BITS'(g);
      ab = ab + CH_BITS'(b);
      add_pixel = {ab, ag, ar};
    end
  endfunction

endpackage

/* src/elca_divider.sv */
// Serial divider: three channel sums by the square area, saturated to 8 bits.
module elca_divider import elca_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_BITS-1:0] sum,
  input  logic [13:0]         area,
  output logic                done,
  output logic [7:0]          q_red,
  output logic [7:0]          q_green,
  output logic [7:0]          q_blue
);

  logic [4:0]          bit_cnt;
  logic                busy;
  logic [CH_BITS-1:0]  num [3];
  logic [CH_BITS-1:0]  quo [3];
  logic [CH_BITS:0]    rem [3];
  logic [CH_BITS:0]    trial [3];

  // form the trial subtraction for each channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem[c][CH_BITS-1:0], num[c][CH_BITS-1]} - {7'd0, area};
    end
  end

  // one quotient bit per cycle for every channel
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bit_cnt <= 5'(CH_BITS);
      end else if (busy) begin
        bit_cnt <= bit_cnt - 5'd1;
        if (bit_cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int c = 0; c < 3; c++) begin
        num[c] <= sum[c*CH_BITS +: CH_BITS];
        rem[c] <= '0;
        quo[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < 3; c++) begin
        num[c] <= {num[c][CH_BITS-2:0], 1'b0};
        if (!trial[c][CH_BITS]) begin
          rem[c] <= trial[c];
          quo[c] <= {quo[c][CH_BITS-2:0], 1'b1};
        end else begin
          rem[c] <= {rem[c][CH_BITS-1:0], num[c][CH_BITS-1]};
          quo[c] <= {quo[c][CH_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // saturate
  assign q_red   = (|quo[0][CH_BITS-1:8]) ? 8'hFF : quo[0][7:0];
  assign q_green = (|quo[1][CH_BITS-1:8]) ? 8'hFF : quo[1][7:0];
  assign q_blue  = (|quo[2][CH_BITS-1:8]) ? 8'hFF : quo[2][7:0];

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for two cycles");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
`endif

endmodule

/* src/elca_sum_store.sv */
// Sum memories for the top and bottom edges, with a registered read.
module elca_sum_store import elca_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  input  logic                rd_bottom,
  output logic [SUM_BITS-1:0] rd_data,
  input  logic                wr_en,
  input  logic                wr_bottom,
  input  logic                wr_all,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SUM_BITS-1:0] wr_data
);

  logic [SUM_BITS-1:0] top_mem [DEPTH];
  logic [SUM_BITS-1:0] bot_mem [DEPTH];
  logic [SUM_BITS-1:0] top_q, bot_q;
  logic                sel_q;

  // write one or both banks, read both banks
  always_ff @(posedge clk) begin
    if (wr_en && (wr_all || !wr_bottom)) top_mem[wr_addr] <= wr_data;
    if (wr_en && (wr_all || wr_bottom)) bot_mem[wr_addr] <= wr_data;
    top_q <= top_mem[rd_addr];
    bot_q <= bot_mem[rd_addr];
    sel_q <= rd_bottom;
  end

  assign rd_data = sel_q ? bot_q : top_q;

endmodule

/* src/edge_led_color_averager_top.sv */
// Top level of the edge LED colour averager.
// Usage:
//   s_axis carries one pixel word per transfer: coordinates and colour.
//   m_axis carries one LED word per transfer: LED index and average colour,
//   tlast set on the last word a pixel causes (at most two words).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Operation:
//   A pixel outside the frame is dropped on acceptance. For a pixel in the
//   frame, each edge band that holds it runs two 23-step serial divisions to
//   locate the square and then, when the pixel lies inside the square, a
//   read-modify-write of that square's sum. Each result then passes through
//   the serial divider.
//   One pixel is worked on at a time; s_axis_tready is low while busy.
// Reset:
//   rst restores register defaults and starts a clearing pass that zeroes the
//   MAX_SIDE_LEDS entries (256 by default) of both edge memories; s_axis_tready
//   stays low until it ends.
// Stall:
//   When m_axis_tready is low the result holds in the output register and
//   the sequencer waits; no word is lost or repeated.
module edge_led_color_averager_top import elca_pkg::*; #(
  parameter int MAX_SIDE_LEDS = 256,
  parameter int MAX_SAMPLE = 64,
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pix_red, pix_green, pix_blue
  input  logic [2*COORD_BITS+23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_index[9:0], avg_red[17:10], avg_green[25:18], avg_blue[33:26]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW = (MAX_SIDE_LEDS > 1) ? $clog2(MAX_SIDE_LEDS) : 1;
  localparam int CW = $clog2(MAX_SIDE_LEDS + 1);
  localparam int SW = $clog2(MAX_SAMPLE + 1);

  // configuration registers
  logic [12:0] frame_width, frame_height;
  logic [8:0]  left_count, right_count, top_count, bottom_count;
  logic [6:0]  sample_size;
  logic        clockwise;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd1920;
      frame_height <= 13'd1080;
      left_count <= '0;
      right_count <= '0;
      top_count <= '0;
      bottom_count <= '0;
      sample_size <= 7'd8;
      clockwise <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:     frame_width <= cfg_data;
        REG_HEIGHT:    frame_height <= cfg_data;
        REG_LEFT:      left_count <= cfg_data[8:0];
        REG_RIGHT:     right_count <= cfg_data[8:0];
        REG_TOP:       top_count <= cfg_data[8:0];
        REG_BOTTOM:    bottom_count <= cfg_data[8:0];
        REG_SAMPLE:    sample_size <= cfg_data[6:0];
        REG_CLOCKWISE: clockwise <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped values
  logic [CW-1:0] c_l, c_r, c_t, c_b;
  logic [SW-1:0] s_c;
  always_comb begin
    c_l = (32'(left_count) > MAX_SIDE_LEDS) ? CW'(MAX_SIDE_LEDS) : CW'(left_count);
    c_r = (32'(right_count) > MAX_SIDE_LEDS) ? CW'(MAX_SIDE_LEDS) : CW'(right_count);
    c_t = (32'(top_count) > MAX_SIDE_LEDS) ? CW'(MAX_SIDE_LEDS) : CW'(top_count);
    c_b = (32'(bottom_count) > MAX_SIDE_LEDS) ? CW'(MAX_SIDE_LEDS) : CW'(bottom_count);
    s_c = (32'(sample_size) > MAX_SAMPLE) ? SW'(MAX_SAMPLE) : SW'(sample_size);
  end

  // captured pixel
  logic [COORD_BITS-1:0] px, py;
  logic [7:0] pr, pg, pb;

  state_t state, state_next;
  logic [1:0] edge_i;          // edge under test
  logic [12:0] pos, dim, other;
  logic [CW-1:0] cnt;
  logic [12:0] s13;
  logic [CW-1:0] kk;
  logic [12:0] st;
  logic        hit;

  // left/right single sums
  logic [SUM_BITS-1:0] left_sum, right_sum;

  // pending results
  logic [1:0]  n_res;
  logic [11:0] res_idx [2];
  logic [SUM_BITS-1:0] res_sum [2];
  logic [0:0]  out_sel;
  logic        out_load;

  // memory
  logic [AW-1:0] mem_addr;
  logic [AW-1:0] mem_waddr;
  logic          mem_bottom;
  logic [SUM_BITS-1:0] mem_rd;
  logic          mem_we;
  logic [SUM_BITS-1:0] mem_wd;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // divider
  logic div_start, div_done;
  logic [SUM_BITS-1:0] div_sum;
  logic [7:0] qr, qg, qb;
  logic [13:0] area;

  assign s13 = 13'(s_c);
  assign area = 14'(s_c) * 14'(s_c);
  assign s_axis_tready = (state == ST_IDLE) && !clearing;

  // zero both edge memories after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (32'(clr_addr) == MAX_SIDE_LEDS - 1) clearing <= 1'b0;
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // pixel lies inside the frame and squares exist
  logic in_frame;
  assign in_frame = (32'(s_axis_tdata[COORD_BITS-1:0]) < 32'(frame_width)) &&
                    (32'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]) < 32'(frame_height)) &&
                    (s_c != '0);

  // per-edge locate inputs
  always_comb begin
    unique case (edge_code_t'(edge_i))
      EDGE_LEFT:   begin pos = 13'(py); dim = frame_height; other = frame_width;  cnt = c_l; end
      EDGE_TOP:    begin pos = 13'(px); dim = frame_width;  other = frame_height; cnt = c_t; end
      EDGE_RIGHT:  begin pos = 13'(py); dim = frame_height; other = frame_width;  cnt = c_r; end
      default:     begin pos = 13'(px); dim = frame_width;  other = frame_height; cnt = c_b; end
    endcase
  end

  // edge membership across the square axis
  logic band;
  logic [12:0] across, ofs;
  always_comb begin
    across = (edge_i[0]) ? 13'(py) : 13'(px);
    ofs = other - s13;
    unique case (edge_code_t'(edge_i))
      EDGE_LEFT, EDGE_TOP: band = across < s13;
      default:             band = across >= ofs;
    endcase
    band = band && (s13 <= other) && (cnt != 0) && (dim != 0);
  end

  // serial index estimate: kk = ((p+1)*cnt-1)/dim done by restoring loop
  logic [22:0] num_q, rem_q;
  logic [4:0]  it;
  logic [23:0] dtrial;
  assign dtrial = {rem_q, num_q[22]} - {11'd0, dim};

  // start product kk*dim / cnt is found by a second serial loop
  logic [22:0] p2;
  logic        phase2;
  logic [23:0] ctrial;
  assign ctrial = {rem_q, num_q[22]} - {(24-CW)'(0), cnt};

  logic fresh, done_sq;
  logic [12:0] first_across, last_along, first_along;
  always_comb begin
    first_along = st;
    last_along = st + s13 - 13'd1;
    first_across = (edge_i[1]) ? ofs : 13'd0;
    fresh = (across == first_across) && (pos == first_along);
    done_sq = (across == ((edge_i[1]) ? other - 13'd1 : s13 - 13'd1)) &&
              (pos == last_along);
  end

  logic [11:0] idx_calc;
  logic [11:0] kx;
  always_comb begin
    kx = 12'(kk);
    unique case (edge_code_t'(edge_i))
      EDGE_LEFT:  idx_calc = clockwise ? 12'(c_l) - 12'd1 - kx : kx;
      EDGE_TOP:   idx_calc = clockwise ? 12'(c_l) + kx :
                  12'(c_l) + 12'(c_b) + 12'(c_r) + 12'(c_t) - 12'd1 - kx;
      EDGE_RIGHT: idx_calc = clockwise ? 12'(c_l) + 12'(c_t) + kx :
                  12'(c_l) + 12'(c_b) + 12'(c_r) - 12'd1 - kx;
      default:    idx_calc = clockwise ?
                  12'(c_l) + 12'(c_t) + 12'(c_r) + 12'(c_b) - 12'd1 - kx : 12'(c_l) + kx;
    endcase
  end

  logic [SUM_BITS-1:0] cur_sum, new_sum;
  always_comb begin
    unique case (edge_code_t'(edge_i))
      EDGE_LEFT:  cur_sum = left_sum;
      EDGE_RIGHT: cur_sum = right_sum;
      default:    cur_sum = mem_rd;
    endcase
    new_sum = add_pixel(cur_sum, fresh, pr, pg, pb);
  end

  assign mem_addr = AW'(kk);
  assign mem_waddr = clearing ? clr_addr : mem_addr;
  assign mem_bottom = (edge_i == EDGE_BOTTOM);
  assign mem_we = ((state == ST_RMW) && edge_i[0]) || clearing;
  assign mem_wd = clearing ? '0 : new_sum;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid && s_axis_tready && in_frame) state_next = ST_EDGE;
      ST_EDGE:   state_next = band ? ST_LOCATE : ((edge_i == EDGE_BOTTOM) ? ST_SORT : ST_EDGE);
      ST_LOCATE: if (it == 5'd0) state_next = phase2 ? ST_LCHK : ST_LMUL;
      ST_LMUL:   state_next = ST_LOCATE;
      ST_LCHK:   state_next = hit ? ST_RMW : ((edge_i == EDGE_BOTTOM) ? ST_SORT : ST_EDGE);
      ST_RMW:    state_next = (edge_i == EDGE_BOTTOM) ? ST_SORT : ST_EDGE;
      ST_SORT:   state_next = (n_res == 2'd0) ? ST_IDLE : ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_OUT;
      ST_OUT:    if (!m_axis_tvalid || m_axis_tready)
                   state_next = (out_sel == 1'b0 && n_res == 2'd2) ? ST_DIV : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign div_start = (state == ST_SORT && n_res != 2'd0) ||
                     (state == ST_OUT && state_next == ST_DIV);
  // first result from the sort step, second when the first is handed out
  assign div_sum = (state == ST_OUT) ? res_sum[1] : res_sum[0];

  // datapath and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      left_sum <= '0;
      right_sum <= '0;
      n_res <= '0;
    end else begin
      state <= state_next;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          px <= s_axis_tdata[COORD_BITS-1:0];
          py <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
          pr <= s_axis_tdata[2*COORD_BITS +: 8];
          pg <= s_axis_tdata[2*COORD_BITS+8 +: 8];
          pb <= s_axis_tdata[2*COORD_BITS+16 +: 8];
          edge_i <= EDGE_LEFT;
          n_res <= '0;
          out_sel <= 1'b0;
        end
        ST_EDGE: begin
          if (band) begin
            num_q <= 23'(pos + 13'd1) * 23'(cnt) - 23'd1;
            rem_q <= '0;
            it <= 5'd23;
            phase2 <= 1'b0;
          end else begin
            edge_i <= edge_i + 2'd1;
          end
        end
        ST_LOCATE: if (it != 5'd0) begin
          it <= it - 5'd1;
          num_q <= {num_q[21:0], 1'b0};
          if (!phase2) begin
            if (!dtrial[23]) begin rem_q <= dtrial[22:0]; p2 <= {p2[21:0], 1'b1}; end
            else begin rem_q <= {rem_q[21:0], num_q[22]}; p2 <= {p2[21:0], 1'b0}; end
          end else begin
            if (!ctrial[23]) begin rem_q <= ctrial[22:0]; p2 <= {p2[21:0], 1'b1}; end
            else begin rem_q <= {rem_q[21:0], num_q[22]}; p2 <= {p2[21:0], 1'b0}; end
          end
        end else if (phase2) begin
          st <= 13'(p2);
        end else begin
          kk <= (p2 >= 23'(cnt)) ? cnt - CW'(1) : CW'(p2);
        end
        ST_LMUL: begin
          num_q <= 23'(kk) * 23'(dim);
          rem_q <= '0;
          it <= 5'd23;
          phase2 <= 1'b1;
        end
        ST_LCHK: begin
          if (!hit) edge_i <= edge_i + 2'd1;
        end
        ST_RMW: begin
          if (edge_i == EDGE_LEFT) left_sum <= new_sum;
          if (edge_i == EDGE_RIGHT) right_sum <= new_sum;
          if (done_sq) begin
            n_res <= (n_res == 2'd2) ? 2'd2 : n_res + 2'd1;
            if (n_res == 2'd0) begin
              res_idx[0] <= idx_calc; res_sum[0] <= new_sum;
            end else if (n_res == 2'd1) begin
              if (idx_calc < res_idx[0]) begin
                res_idx[1] <= res_idx[0]; res_sum[1] <= res_sum[0];
                res_idx[0] <= idx_calc; res_sum[0] <= new_sum;
              end else begin
                res_idx[1] <= idx_calc; res_sum[1] <= new_sum;
              end
            end else begin
              if (idx_calc < res_idx[0]) begin
                res_idx[1] <= res_idx[0]; res_sum[1] <= res_sum[0];
                res_idx[0] <= idx_calc; res_sum[0] <= new_sum;
              end else if (idx_calc < res_idx[1]) begin
                res_idx[1] <= idx_calc; res_sum[1] <= new_sum;
              end
            end
          end
          edge_i <= edge_i + 2'd1;
        end
        ST_OUT: if (out_load) begin
          m_axis_tdata <= {6'd0, qb, qg, qr, res_idx[out_sel][9:0]};
          m_axis_tlast <= (out_sel == 1'b1) || (n_res == 2'd1);
          out_sel <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // square fit check after the start is known
  assign hit = (pos >= st) && ((pos - st) < s13) && ({1'b0, st} + {1'b0, s13} <= {1'b0, dim});

  elca_sum_store #(.DEPTH(MAX_SIDE_LEDS), .AW(AW)) u_store (
    .clk(clk), .rd_addr(mem_addr), .rd_bottom(mem_bottom), .rd_data(mem_rd),
    .wr_en(mem_we), .wr_bottom(mem_bottom), .wr_all(clearing), .wr_addr(mem_waddr),
    .wr_data(mem_wd)
  );

  elca_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .sum(div_sum), .area(area),
    .done(div_done), .q_red(qr), .q_green(qg), .q_blue(qb)
  );

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !(state == ST_DIV || state == ST_OUT))
    else $error("ready while results pending");
  a_two_max: assert property (@(posedge clk) disable iff (rst) n_res != 2'd3)
    else $error("too many results");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule
